### hw/rtl/dsa_pkg.sv
package dsa_pkg;

  // Default sizing of the slot store.
  localparam int HEAP_DEPTH_DEF = 1024;
  localparam int FRAMES_DEF     = 3;

  // Fixed field widths.
  localparam int CAP_W  = 11;
  localparam int SIZE_W = 13;
  localparam int ADDR_W = 64;
  localparam int CMD_W  = 2;
  localparam int FRM_W  = 2;
  localparam int STAT_W = 2;
  localparam int CFG_IW = 3;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_ALLOC  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FREE   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RETIRE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_INIT   = 2'd3;

  // Status codes.
  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd1;
  localparam logic [STAT_W-1:0] ST_BAD  = 2'd2;
  localparam logic [STAT_W-1:0] ST_NULL = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IW-1:0] REG_CAPACITY = 3'd0;
  localparam logic [CFG_IW-1:0] REG_SLOT_SIZE = 3'd1;
  localparam logic [CFG_IW-1:0] REG_CPU_BASE = 3'd2;
  localparam logic [CFG_IW-1:0] REG_GPU_BASE = 3'd3;
  localparam logic [CFG_IW-1:0] REG_VISIBLE  = 3'd4;

endpackage

### hw/rtl/dsa_div.sv
// Restoring divider: one quotient bit per cycle.
module dsa_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [dsa_pkg::ADDR_W-1:0]     dividend,
  input  logic [dsa_pkg::SIZE_W-1:0]     divisor,
  output logic                           done,
  output logic [dsa_pkg::ADDR_W-1:0]     quotient,
  output logic [dsa_pkg::SIZE_W-1:0]     remainder
);

  localparam int CNT_W = $clog2(dsa_pkg::ADDR_W + 1);

  logic [CNT_W-1:0]            count;
  logic                        running;
  logic [dsa_pkg::SIZE_W:0]    trial;
  logic [dsa_pkg::SIZE_W:0]    diff;

  // Shift in the next dividend bit and try the subtraction.
  always_comb begin
    trial = {remainder, quotient[dsa_pkg::ADDR_W-1]};
    diff  = trial - {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      count   <= '0;
    end else begin
      // The last quotient bit raises done for one cycle.
      done <= !start && running && count == CNT_W'(1);
      if (start) begin
        running   <= 1'b1;
        count     <= CNT_W'(dsa_pkg::ADDR_W);
        quotient  <= dividend;
        remainder <= '0;
      end else if (running) begin
        if (trial >= {1'b0, divisor}) begin
          remainder <= diff[dsa_pkg::SIZE_W-1:0];
          quotient  <= {quotient[dsa_pkg::ADDR_W-2:0], 1'b1};
        end else begin
          remainder <= trial[dsa_pkg::SIZE_W-1:0];
          quotient  <= {quotient[dsa_pkg::ADDR_W-2:0], 1'b0};
        end
        count <= count - CNT_W'(1);
        if (count == CNT_W'(1)) begin
          running <= 1'b0;
        end
      end
    end
  end

endmodule

### hw/rtl/descriptor_slot_allocator.sv
// Channel   | Signals                                    | Handshake
// command   | cmd, slot_address, frame_slot              | start, taken when busy is low
// result    | status, cpu_address, gpu_address, slot_index | done, one cycle, no stall
// config    | cfg_write, cfg_index, cfg_data             | taken at every cfg_write edge
//
// One item at a time. Allocate runs a check, a multiply and an add; free of a good
// address is bound by the bit-serial divider; retire reads and pushes each queued
// index in turn; init sweeps the free stack memory.
// After reset the same sweep runs with busy high.
// Results cannot be held off by the receiver.
module descriptor_slot_allocator #(
  parameter int HEAP_DEPTH = dsa_pkg::HEAP_DEPTH_DEF,
  parameter int FRAMES     = dsa_pkg::FRAMES_DEF,
  localparam int IW = $clog2(HEAP_DEPTH)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [dsa_pkg::CMD_W-1:0]     cmd,
  input  logic [dsa_pkg::ADDR_W-1:0]    slot_address,
  input  logic [dsa_pkg::FRM_W-1:0]     frame_slot,
  input  logic                          cfg_write,
  input  logic [dsa_pkg::CFG_IW-1:0]    cfg_index,
  input  logic [dsa_pkg::ADDR_W-1:0]    cfg_data,
  output logic                          done,
  output logic [dsa_pkg::STAT_W-1:0]    status,
  output logic [dsa_pkg::ADDR_W-1:0]    cpu_address,
  output logic [dsa_pkg::ADDR_W-1:0]    gpu_address,
  output logic [IW-1:0]                 slot_index
);

  localparam int CW   = $clog2(HEAP_DEPTH + 1);
  localparam int FIW  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int PD   = FRAMES * HEAP_DEPTH;
  localparam int PAW  = $clog2(PD);
  localparam int OFFW = IW + dsa_pkg::SIZE_W;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CLEAR  = 4'd1;
  localparam logic [3:0] S_AL_CHK = 4'd2;
  localparam logic [3:0] S_AL_MUL = 4'd3;
  localparam logic [3:0] S_AL_ADD = 4'd4;
  localparam logic [3:0] S_FR_CHK = 4'd5;
  localparam logic [3:0] S_FR_DIV = 4'd6;
  localparam logic [3:0] S_FR_END = 4'd7;
  localparam logic [3:0] S_RT_RD  = 4'd8;
  localparam logic [3:0] S_RT_WR  = 4'd9;

  // Configuration registers.
  logic [dsa_pkg::CAP_W-1:0]  heap_capacity;
  logic [dsa_pkg::SIZE_W-1:0] slot_size;
  logic [dsa_pkg::ADDR_W-1:0] cpu_base;
  logic [dsa_pkg::ADDR_W-1:0] gpu_base;
  logic                       shader_visible;

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_capacity  <= dsa_pkg::CAP_W'(1024);
      slot_size      <= dsa_pkg::SIZE_W'(32);
      cpu_base       <= '0;
      gpu_base       <= '0;
      shader_visible <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        dsa_pkg::REG_CAPACITY:  heap_capacity  <= cfg_data[dsa_pkg::CAP_W-1:0];
        dsa_pkg::REG_SLOT_SIZE: slot_size      <= cfg_data[dsa_pkg::SIZE_W-1:0];
        dsa_pkg::REG_CPU_BASE:  cpu_base       <= cfg_data;
        dsa_pkg::REG_GPU_BASE:  gpu_base       <= cfg_data;
        dsa_pkg::REG_VISIBLE:   shader_visible <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Capacity clipped to the store depth.
  logic [CW-1:0] cap_eff;
  always_comb begin
    if (32'(heap_capacity) > HEAP_DEPTH) cap_eff = CW'(HEAP_DEPTH);
    else cap_eff = CW'(heap_capacity);
  end

  // Control state.
  logic [3:0]                  state;
  logic [CW-1:0]               used;
  logic [CW-1:0]               total;
  logic [CW-1:0]               pcount [FRAMES];
  logic [IW-1:0]               sweep;
  logic                        sweep_reply;
  logic [CW-1:0]               k;
  logic [dsa_pkg::ADDR_W-1:0]  addr_q;
  logic [dsa_pkg::FRM_W-1:0]   frame_q;
  logic [OFFW-1:0]             offset;
  logic [FIW-1:0]              fidx;
  logic                        frame_bad;

  assign fidx      = FIW'(frame_q);
  assign frame_bad = 32'(frame_q) >= FRAMES;
  assign busy      = state != S_IDLE;

  // Free stack memory.
  logic [IW-1:0] stack_mem [HEAP_DEPTH];
  logic          st_we;
  logic [IW-1:0] st_waddr, st_wdata, st_raddr, st_rdata;

  always_ff @(posedge clk) begin
    if (st_we) stack_mem[st_waddr] <= st_wdata;
    st_rdata <= stack_mem[st_raddr];
  end

  // Pending list memory, one HEAP_DEPTH region per frame.
  logic [IW-1:0]  pend_mem [PD];
  logic           pd_we;
  logic [PAW-1:0] pd_waddr, pd_raddr, pd_base;
  logic [IW-1:0]  pd_wdata, pd_rdata;

  always_ff @(posedge clk) begin
    if (pd_we) pend_mem[pd_waddr] <= pd_wdata;
    pd_rdata <= pend_mem[pd_raddr];
  end

  assign pd_base = PAW'(frame_q) * PAW'(HEAP_DEPTH);

  // Divider for address to index conversion.
  logic                           div_start;
  logic                           div_done;
  logic [dsa_pkg::ADDR_W-1:0]     quo;
  logic [dsa_pkg::SIZE_W-1:0]     rem;

  dsa_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (addr_q - cpu_base),
    .divisor   (slot_size),
    .done      (div_done),
    .quotient  (quo),
    .remainder (rem)
  );

  // Memory port selection from the sequencer state.
  always_comb begin
    st_we     = 1'b0;
    st_waddr  = sweep;
    st_wdata  = sweep;
    st_raddr  = used[IW-1:0];
    pd_we     = 1'b0;
    pd_waddr  = pd_base + PAW'(pcount[fidx]);
    pd_wdata  = quo[IW-1:0];
    pd_raddr  = pd_base + PAW'(k);
    div_start = 1'b0;
    unique case (state)
      S_CLEAR: st_we = 1'b1;
      S_RT_WR: begin
        st_we    = 1'b1;
        st_waddr = IW'(used - CW'(1));
        st_wdata = pd_rdata;
      end
      S_FR_CHK: div_start = !(addr_q == '0 || frame_bad || slot_size == '0 ||
                              addr_q < cpu_base);
      S_FR_END: pd_we = !(rem != '0 || quo >= 64'(cap_eff) || total >= used ||
                          pcount[fidx] >= CW'(HEAP_DEPTH));
      default: ;
    endcase
  end

  // Sequencer. The result strobe is raised on the way back to idle and
  // dropped by the first idle cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      sweep       <= '0;
      sweep_reply <= 1'b0;
      used        <= '0;
      total       <= '0;
      done        <= 1'b0;
      for (int f = 0; f < FRAMES; f++) pcount[f] <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          done <= 1'b0;
          if (start) begin
            addr_q  <= slot_address;
            frame_q <= frame_slot;
            k       <= '0;
            unique case (cmd)
              dsa_pkg::CMD_ALLOC:  state <= S_AL_CHK;
              dsa_pkg::CMD_FREE:   state <= S_FR_CHK;
              dsa_pkg::CMD_RETIRE: state <= S_RT_RD;
              dsa_pkg::CMD_INIT: begin
                state       <= S_CLEAR;
                sweep       <= '0;
                sweep_reply <= 1'b1;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        // Identity rebuild of the free stack, lists emptied.
        S_CLEAR: begin
          used  <= '0;
          total <= '0;
          for (int f = 0; f < FRAMES; f++) pcount[f] <= '0;
          sweep <= sweep + IW'(1);
          if (sweep == IW'(HEAP_DEPTH - 1)) begin
            state <= S_IDLE;
            if (sweep_reply) begin
              done        <= 1'b1;
              status      <= dsa_pkg::ST_OK;
              cpu_address <= '0;
              gpu_address <= '0;
              slot_index  <= '0;
            end
          end
        end
        // Allocate: the stack read is issued here.
        S_AL_CHK: begin
          if (used >= cap_eff) begin
            state       <= S_IDLE;
            done        <= 1'b1;
            status      <= dsa_pkg::ST_FULL;
            cpu_address <= '0;
            gpu_address <= '0;
            slot_index  <= '0;
          end else begin
            state <= S_AL_MUL;
          end
        end
        S_AL_MUL: begin
          offset     <= OFFW'(st_rdata) * OFFW'(slot_size);
          slot_index <= st_rdata;
          used       <= used + CW'(1);
          state      <= S_AL_ADD;
        end
        S_AL_ADD: begin
          state       <= S_IDLE;
          done        <= 1'b1;
          status      <= dsa_pkg::ST_OK;
          cpu_address <= cpu_base + 64'(offset);
          gpu_address <= shader_visible ? gpu_base + 64'(offset) : '0;
        end
        // Free: early checks, then the division.
        S_FR_CHK: begin
          if (div_start) begin
            state <= S_FR_DIV;
          end else begin
            state       <= S_IDLE;
            done        <= 1'b1;
            status      <= (addr_q == '0) ? dsa_pkg::ST_NULL : dsa_pkg::ST_BAD;
            cpu_address <= '0;
            gpu_address <= '0;
            slot_index  <= '0;
          end
        end
        S_FR_DIV: if (div_done) state <= S_FR_END;
        S_FR_END: begin
          state       <= S_IDLE;
          done        <= 1'b1;
          cpu_address <= '0;
          gpu_address <= '0;
          if (pd_we) begin
            pcount[fidx] <= pcount[fidx] + CW'(1);
            total        <= total + CW'(1);
            status       <= dsa_pkg::ST_OK;
            slot_index   <= quo[IW-1:0];
          end else begin
            status     <= dsa_pkg::ST_BAD;
            slot_index <= '0;
          end
        end
        // Retire: read a pending entry, then push it on the stack.
        S_RT_RD: begin
          if (frame_bad || k == pcount[fidx] || used == '0) begin
            state       <= S_IDLE;
            done        <= 1'b1;
            status      <= frame_bad ? dsa_pkg::ST_BAD : dsa_pkg::ST_OK;
            cpu_address <= '0;
            gpu_address <= '0;
            slot_index  <= '0;
            if (!frame_bad) begin
              pcount[fidx] <= '0;
              total        <= total - pcount[fidx];
            end
          end else begin
            state <= S_RT_WR;
          end
        end
        S_RT_WR: begin
          used  <= used - CW'(1);
          k     <= k + CW'(1);
          state <= S_RT_RD;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### hw/rtl/dsa_checker.sv
module dsa_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        start,
  input logic                        busy,
  input logic                        done,
  input logic [dsa_pkg::STAT_W-1:0]  status,
  input logic [dsa_pkg::ADDR_W-1:0]  cpu_address,
  input logic [dsa_pkg::ADDR_W-1:0]  gpu_address
);

  // An accepted item keeps the block busy.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("item accepted but block not busy");

  // A result closes an item that was in flight.
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy) && !busy) else $error("result without an item");

  // Result strobes never come back to back.
  a_single_result: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("repeated result strobe");

  // A failed item returns no addresses (only a good allocate returns them).
  a_zero_addr: assert property (@(posedge clk) disable iff (rst)
    done && status != dsa_pkg::ST_OK |-> cpu_address == '0 && gpu_address == '0)
    else $error("address on a failed item");

endmodule

bind descriptor_slot_allocator dsa_checker u_dsa_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .done        (done),
  .status      (status),
  .cpu_address (cpu_address),
  .gpu_address (gpu_address)
);

### tb/tb.sv
`timescale 1ns / 100ps

module tb;

  localparam int DEPTH  = dsa_pkg::HEAP_DEPTH_DEF;
  localparam int NFRM   = dsa_pkg::FRAMES_DEF;
  localparam int CMD_W  = dsa_pkg::CMD_W;
  localparam int FRM_W  = dsa_pkg::FRM_W;
  localparam int STAT_W = dsa_pkg::STAT_W;
  localparam int ADDR_W = dsa_pkg::ADDR_W;
  localparam int CAP_W  = dsa_pkg::CAP_W;
  localparam int SIZE_W = dsa_pkg::SIZE_W;
  localparam int CFG_IW = dsa_pkg::CFG_IW;
  localparam logic [FRM_W-1:0] FRAME_BAD = 2'd3;

  typedef struct packed {
    logic [STAT_W-1:0] st;
    logic [ADDR_W-1:0] cpu;
    logic [ADDR_W-1:0] gpu;
    logic [9:0]        idx;
  } slot_result_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  logic [CMD_W-1:0]  cmd = dsa_pkg::CMD_ALLOC;
  logic [ADDR_W-1:0] slot_address = '0;
  logic [FRM_W-1:0]  frame_slot = '0;
  logic              cfg_write = 1'b0;
  logic [CFG_IW-1:0] cfg_index = dsa_pkg::REG_CAPACITY;
  logic [ADDR_W-1:0] cfg_data = '0;
  logic              done;
  logic [STAT_W-1:0] status;
  logic [ADDR_W-1:0] cpu_address;
  logic [ADDR_W-1:0] gpu_address;
  logic [9:0]        slot_index;

  // Shadow copy of the allocator state and registers.
  logic [9:0]        free_stk[DEPTH];
  logic [9:0]        pend_list[NFRM][DEPTH];
  int                pend_cnt[NFRM];
  int                used_cnt;
  logic [CAP_W-1:0]  cap_reg;
  logic [SIZE_W-1:0] size_reg;
  logic [ADDR_W-1:0] cpu_base_reg;
  logic [ADDR_W-1:0] gpu_base_reg;
  logic              visible_reg;

  slot_result_t expected_results[$];
  int mismatches = 0;
  int items_sent = 0;
  int cmd_seen[4];
  int status_seen[4];
  bit calm = 1'b0;

  descriptor_slot_allocator u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .slot_address(slot_address), .frame_slot(frame_slot), .cfg_write(cfg_write),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .done(done), .status(status),
    .cpu_address(cpu_address), .gpu_address(gpu_address), .slot_index(slot_index)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #200ms;
    $display("descriptor_slot_allocator verification failed");
    $finish;
  end

  // Restore the identity free list and empty every pending list.
  function automatic void clear_slots();
    for (int i = 0; i < DEPTH; i++) free_stk[i] = 10'(i);
    used_cnt = 0;
    for (int f = 0; f < NFRM; f++) pend_cnt[f] = 0;
  endfunction

  // Work out the result of one command and advance the shadow state.
  function automatic slot_result_t apply_slot_cmd(logic [CMD_W-1:0] c,
                                                  logic [ADDR_W-1:0] a,
                                                  logic [FRM_W-1:0] f);
    slot_result_t r;
    int cap_eff;
    int total;
    logic [ADDR_W-1:0] off;
    logic [ADDR_W-1:0] diff;
    logic [ADDR_W-1:0] q;
    r = '0;
    r.st = dsa_pkg::ST_OK;
    cap_eff = (cap_reg > DEPTH) ? DEPTH : int'(cap_reg);
    total = 0;
    for (int k = 0; k < NFRM; k++) total += pend_cnt[k];
    case (c)
      dsa_pkg::CMD_ALLOC: begin
        if (used_cnt >= cap_eff) begin
          r.st = dsa_pkg::ST_FULL;
        end else begin
          off = 64'(free_stk[used_cnt]) * 64'(size_reg);
          r.idx = free_stk[used_cnt];
          r.cpu = cpu_base_reg + off;
          r.gpu = visible_reg ? gpu_base_reg + off : '0;
          used_cnt++;
        end
      end
      dsa_pkg::CMD_FREE: begin
        if (a == '0) begin
          r.st = dsa_pkg::ST_NULL;
        end else if (f >= NFRM || size_reg == '0 || a < cpu_base_reg) begin
          r.st = dsa_pkg::ST_BAD;
        end else begin
          diff = a - cpu_base_reg;
          q = diff / 64'(size_reg);
          if (diff % 64'(size_reg) != '0 || q >= 64'(cap_eff) || total >= used_cnt ||
              pend_cnt[f] >= DEPTH) begin
            r.st = dsa_pkg::ST_BAD;
          end else begin
            pend_list[f][pend_cnt[f]] = q[9:0];
            pend_cnt[f]++;
            r.idx = q[9:0];
          end
        end
      end
      dsa_pkg::CMD_RETIRE: begin
        if (f >= NFRM) begin
          r.st = dsa_pkg::ST_BAD;
        end else begin
          for (int k = 0; k < pend_cnt[f] && used_cnt > 0; k++) begin
            used_cnt--;
            free_stk[used_cnt] = pend_list[f][k];
          end
          pend_cnt[f] = 0;
        end
      end
      default: clear_slots();
    endcase
    return r;
  endfunction

  // Compare each result with the oldest expectation.
  always @(posedge clk) begin
    slot_result_t want;
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: status %0d cpu %h", status,
                                       cpu_address);
      end else begin
        want = expected_results.pop_front();
        status_seen[want.st]++;
        if (status !== want.st || cpu_address !== want.cpu || gpu_address !== want.gpu ||
            slot_index !== want.idx) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: status %0d/%0d cpu %h/%h gpu %h/%h index %0d/%0d (exp/act)",
                     want.st, status, want.cpu, cpu_address, want.gpu, gpu_address,
                     want.idx, slot_index);
        end
      end
    end
  end

  // Present one item, wait until it is taken, and record its expected result.
  task automatic send_item(logic [CMD_W-1:0] c, logic [ADDR_W-1:0] a, logic [FRM_W-1:0] f);
    int r;
    int gap;
    r = $urandom_range(0, 99);
    gap = (calm || r < 70) ? 0 : (r < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    cmd <= c;
    slot_address <= a;
    frame_slot <= f;
    do @(posedge clk); while (busy);
    expected_results.insert(expected_results.size(), apply_slot_cmd(c, a, f));
    cmd_seen[c]++;
    items_sent++;
  endtask

  // Stop sending and wait until every result is in and the block is idle.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0 || busy) @(posedge clk);
  endtask

  // One register write; the caller drops the write enable afterwards.
  task automatic write_reg(logic [CFG_IW-1:0] i, logic [ADDR_W-1:0] d);
    cfg_write <= 1'b1;
    cfg_index <= i;
    cfg_data <= d;
    @(posedge clk);
    case (i)
      dsa_pkg::REG_CAPACITY:  cap_reg = d[CAP_W-1:0];
      dsa_pkg::REG_SLOT_SIZE: size_reg = d[SIZE_W-1:0];
      dsa_pkg::REG_CPU_BASE:  cpu_base_reg = d;
      dsa_pkg::REG_GPU_BASE:  gpu_base_reg = d;
      default:                visible_reg = d[0];
    endcase
  endtask

  task automatic set_heap(logic [ADDR_W-1:0] cap, logic [ADDR_W-1:0] sz, logic [ADDR_W-1:0] cb,
                          logic [ADDR_W-1:0] gb, logic [ADDR_W-1:0] vis);
    drain();
    write_reg(dsa_pkg::REG_CAPACITY, cap);
    write_reg(dsa_pkg::REG_SLOT_SIZE, sz);
    write_reg(dsa_pkg::REG_CPU_BASE, cb);
    write_reg(dsa_pkg::REG_GPU_BASE, gb);
    write_reg(dsa_pkg::REG_VISIBLE, vis);
    cfg_write <= 1'b0;
  endtask

  // Error paths and edge cases of every command.
  task automatic test_directed();
    calm = 1'b1;
    send_item(dsa_pkg::CMD_ALLOC, '0, 2'd0);
    send_item(dsa_pkg::CMD_ALLOC, '0, 2'd0);
    send_item(dsa_pkg::CMD_FREE, '0, 2'd0);
    send_item(dsa_pkg::CMD_FREE, 64'd32, FRAME_BAD);
    send_item(dsa_pkg::CMD_FREE, 64'd33, 2'd1);
    send_item(dsa_pkg::CMD_FREE, 64'd32 * 1024, 2'd1);
    send_item(dsa_pkg::CMD_FREE, 64'd32, 2'd2);
    send_item(dsa_pkg::CMD_FREE, 64'd32, 2'd0);
    send_item(dsa_pkg::CMD_FREE, 64'd32, 2'd1);
    send_item(dsa_pkg::CMD_RETIRE, '0, FRAME_BAD);
    send_item(dsa_pkg::CMD_RETIRE, '0, 2'd2);
    send_item(dsa_pkg::CMD_INIT, '0, 2'd0);
    // Wrapping addresses, visible heap, address below the base.
    set_heap(2047, 8191, 64'hFFFF_FFFF_FFFF_FFE0, 64'hFFFF_FFFF_FFFF_FFFF, 1);
    send_item(dsa_pkg::CMD_ALLOC, '0, 2'd0);
    send_item(dsa_pkg::CMD_ALLOC, '0, 2'd0);
    send_item(dsa_pkg::CMD_FREE, 64'h10, 2'd0);
    send_item(dsa_pkg::CMD_FREE, 64'hFFFF_FFFF_FFFF_FFE0, 2'd0);
    send_item(dsa_pkg::CMD_RETIRE, '0, 2'd0);
    // Zero stride makes every free bad; a single slot fills at once.
    set_heap(1, 0, 64'h1000, 64'h2000, 1);
    send_item(dsa_pkg::CMD_INIT, '0, 2'd0);
    send_item(dsa_pkg::CMD_ALLOC, '0, 2'd0);
    send_item(dsa_pkg::CMD_ALLOC, '0, 2'd0);
    send_item(dsa_pkg::CMD_FREE, 64'h1000, 2'd0);
    // Empty heap.
    set_heap(0, 1, 0, 0, 0);
    send_item(dsa_pkg::CMD_ALLOC, '0, 2'd0);
    send_item(dsa_pkg::CMD_INIT, '0, 2'd0);
    calm = 1'b0;
  endtask

  // Mostly well-formed traffic on one heap setting, with some noise mixed in.
  task automatic test_random_heap(int n, logic [ADDR_W-1:0] cap, logic [ADDR_W-1:0] sz,
                                  logic [ADDR_W-1:0] cb, logic [ADDR_W-1:0] gb, logic vis,
                                  bit quiet);
    int r;
    logic [ADDR_W-1:0] a;
    set_heap(cap, sz, cb, gb, 64'(vis));
    calm = quiet;
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 40) begin
        send_item(dsa_pkg::CMD_ALLOC, {$urandom, $urandom}, 2'($urandom_range(0, 3)));
      end else if (r < 70) begin
        a = used_cnt > 0 ?
            cpu_base_reg + 64'(free_stk[$urandom_range(0, used_cnt - 1)]) * 64'(size_reg) : '0;
        send_item(dsa_pkg::CMD_FREE, a, 2'($urandom_range(0, 2)));
      end else if (r < 82) begin
        send_item(dsa_pkg::CMD_RETIRE, {$urandom, $urandom}, 2'($urandom_range(0, 2)));
      end else if (r < 84) begin
        send_item(dsa_pkg::CMD_INIT, {$urandom, $urandom}, 2'($urandom_range(0, 3)));
      end else if (r < 92) begin
        send_item(dsa_pkg::CMD_FREE, {$urandom, $urandom}, 2'($urandom_range(0, 3)));
      end else if (r < 96) begin
        a = cpu_base_reg + 64'($urandom_range(0, 2047)) * 64'(size_reg) +
            64'($urandom_range(0, 1));
        send_item(dsa_pkg::CMD_FREE, a, 2'($urandom_range(0, 3)));
      end else begin
        send_item(dsa_pkg::CMD_RETIRE, '0, FRAME_BAD);
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    for (int k = 0; k < 4; k++) begin
      cmd_seen[k] = 0;
      status_seen[k] = 0;
    end
    cap_reg = 11'd1024;
    size_reg = 13'd32;
    cpu_base_reg = '0;
    gpu_base_reg = '0;
    visible_reg = 1'b0;
    clear_slots();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_heap(280, 1024, 32, 0, 0, 0, 0);
    test_random_heap(270, 4, 4096, {$urandom, $urandom}, {$urandom, $urandom}, 1, 0);
    test_random_heap(270, 2047, 1, 64'hFFFF_FFFF_FFFF_FC00, 64'hFFFF_FFFF_FFFF_FFFF, 1, 1);
    test_random_heap(270, 17, 7, {$urandom, $urandom}, {$urandom, $urandom}, 1, 0);
    test_random_heap(270, 1, 4095, 64'h8000_0000_0000_0000, 0, 0, 0);
    test_random_heap(270, 60, 8191, {$urandom, $urandom}, {$urandom, $urandom}, 1, 0);
    drain();
    repeat (80) @(posedge clk);
    $display("covered %0d items: %0d allocate, %0d free, %0d retire, %0d init", items_sent,
             cmd_seen[dsa_pkg::CMD_ALLOC], cmd_seen[dsa_pkg::CMD_FREE],
             cmd_seen[dsa_pkg::CMD_RETIRE], cmd_seen[dsa_pkg::CMD_INIT]);
    $display("statuses: %0d ok, %0d full, %0d bad, %0d null; %0d mismatches",
             status_seen[dsa_pkg::ST_OK], status_seen[dsa_pkg::ST_FULL],
             status_seen[dsa_pkg::ST_BAD], status_seen[dsa_pkg::ST_NULL], mismatches);
    if (mismatches == 0) begin
      $display("descriptor_slot_allocator verification clean");
    end else begin
      $display("descriptor_slot_allocator verification failed");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/dsa_pkg.sv
hw/rtl/dsa_div.sv
hw/rtl/descriptor_slot_allocator.sv
hw/rtl/dsa_checker.sv
tb/tb.sv
